// ===== src/pip_pkg.sv =====
// Shared widths and word types for the point-in-polygon crossing test.
// No dependencies; every other file in src refers to it by scoped names.
`default_nettype none

package pip_pkg;

	localparam int COORD_BITS = 32;
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;

	// differences for one edge, formed at the input
	typedef struct packed {
		logic                     straddle;
		logic                     dy_pos;
		logic signed [DIFF_W-1:0] dyi;
		logic signed [DIFF_W-1:0] dxj;
		logic signed [DIFF_W-1:0] dxp;
		logic signed [DIFF_W-1:0] dy;
	} edge_diff_t;

	// exact cross products for one edge
	typedef struct packed {
		logic                     straddle;
		logic                     dy_pos;
		logic signed [PROD_W-1:0] lhs;
		logic signed [PROD_W-1:0] rhs;
	} edge_prod_t;

endpackage

`default_nettype wire

// ===== src/pip_edge_diff.sv =====
// Edge difference logic: straddle test and coordinate differences of one edge.
// Depends on pip_pkg.
`default_nettype none

module pip_edge_diff (
	input  wire logic signed [pip_pkg::COORD_BITS-1:0] xi,
	input  wire logic signed [pip_pkg::COORD_BITS-1:0] yi,
	input  wire logic signed [pip_pkg::COORD_BITS-1:0] xj,
	input  wire logic signed [pip_pkg::COORD_BITS-1:0] yj,
	input  wire logic signed [pip_pkg::COORD_BITS-1:0] px,
	input  wire logic signed [pip_pkg::COORD_BITS-1:0] py,
	output pip_pkg::edge_diff_t                        diff
);

	logic signed [pip_pkg::DIFF_W-1:0] dy;

	assign dy = pip_pkg::DIFF_W'(yj) - pip_pkg::DIFF_W'(yi);

	always_comb begin
		diff.straddle = (yi < py) != (yj < py);
		diff.dy_pos   = dy > 0;
		diff.dyi      = pip_pkg::DIFF_W'(py) - pip_pkg::DIFF_W'(yi);
		diff.dxj      = pip_pkg::DIFF_W'(xj) - pip_pkg::DIFF_W'(xi);
		diff.dxp      = pip_pkg::DIFF_W'(px) - pip_pkg::DIFF_W'(xi);
		diff.dy       = dy;
	end

endmodule

`default_nettype wire

// ===== src/pip_edge_mul.sv =====
// Product stage: both cross products of one edge, registered.
// Depends on pip_pkg.
`default_nettype none

module pip_edge_mul (
	input  wire logic                clk,
	input  wire logic                load,
	input  wire pip_pkg::edge_diff_t diff_s1,
	output pip_pkg::edge_prod_t      prod_s2
);

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s2.straddle <= diff_s1.straddle;
			prod_s2.dy_pos   <= diff_s1.dy_pos;
			prod_s2.lhs      <= pip_pkg::PROD_W'($signed(diff_s1.dyi))
			                  * pip_pkg::PROD_W'($signed(diff_s1.dxj));
			prod_s2.rhs      <= pip_pkg::PROD_W'($signed(diff_s1.dxp))
			                  * pip_pkg::PROD_W'($signed(diff_s1.dy));
		end
	end

endmodule

`default_nettype wire

// ===== src/pip_edge_cmp.sv =====
// Crossing decision from the registered cross products of one edge.
// Depends on pip_pkg.
`default_nettype none

module pip_edge_cmp (
	input  wire pip_pkg::edge_prod_t prod,
	output logic                     crossed
);

	logic lt;
	logic gt;

	assign lt = $signed(prod.lhs) < $signed(prod.rhs);
	assign gt = $signed(prod.rhs) < $signed(prod.lhs);

	// flip the sense of the compare when the edge runs downwards
	assign crossed = prod.straddle && (prod.dy_pos ? lt : gt);

endmodule

`default_nettype wire

// ===== src/point_in_polygon_test.sv =====
// Even-odd point-in-polygon test, top level.
// Depends on pip_pkg, pip_edge_diff, pip_edge_mul and pip_edge_cmp.
//
// Usage:
//   Input channel (in_valid / in_stall): one word per polygon vertex, carrying
//   the vertex, the query point and last_vertex, set on the polygon's final
//   corner. The first word of a polygon is latched as the closing vertex.
//   Output channel (out_valid / out_stall): one word per polygon, inside_res,
//   given when the word marked last_vertex has been processed.
//   Throughput: one vertex per cycle while in_stall is low. Each word passes
//   three registers: differences at the input, the cross products, then the
//   compare and parity update into the result register. out_valid for a
//   polygon rises when its last vertex retires from the compare stage.
//   Each vertex tests both of its edges in parallel: back to the previous vertex, and
//   back to the first vertex (used only on the last word). Four 33x33
//   multipliers in the product stage set the clock period.
//   Stall: a waiting result blocks only the next last_vertex word at the
//   compare stage; ordinary vertices keep flowing into the parity until that
//   point, then the pipe fills and in_stall rises.
//   Reset: clears pipeline valids, the parity, the polygon-open flag and the
//   result valid; stored vertices are rewritten before use.
`default_nettype none

module point_in_polygon_test (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [pip_pkg::COORD_BITS-1:0] vertex_x,
	input  wire logic signed [pip_pkg::COORD_BITS-1:0] vertex_y,
	input  wire logic signed [pip_pkg::COORD_BITS-1:0] point_x,
	input  wire logic signed [pip_pkg::COORD_BITS-1:0] point_y,
	input  wire logic                                  last_vertex,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic                                       inside_res
);

	// polygon tracking
	logic                                  in_poly_q;
	logic signed [pip_pkg::COORD_BITS-1:0] first_x_q;
	logic signed [pip_pkg::COORD_BITS-1:0] first_y_q;
	logic signed [pip_pkg::COORD_BITS-1:0] prev_x_q;
	logic signed [pip_pkg::COORD_BITS-1:0] prev_y_q;
	logic signed [pip_pkg::COORD_BITS-1:0] close_x;
	logic signed [pip_pkg::COORD_BITS-1:0] close_y;

	// pipeline
	pip_pkg::edge_diff_t prev_diff;
	pip_pkg::edge_diff_t close_diff;
	pip_pkg::edge_diff_t prev_diff_s1;
	pip_pkg::edge_diff_t close_diff_s1;
	pip_pkg::edge_prod_t prev_prod_s2;
	pip_pkg::edge_prod_t close_prod_s2;
	logic                v_s1;
	logic                last_s1;
	logic                edge_ok_s1;
	logic                v_s2;
	logic                last_s2;
	logic                edge_ok_s2;
	logic                prev_cross;
	logic                close_cross;
	logic                flip;

	// handshake and result
	logic accept;
	logic move2;
	logic load2;
	logic parity_q;
	logic out_valid_q;

	// closing edge of a one-vertex polygon runs from the vertex to itself
	assign close_x = in_poly_q ? first_x_q : vertex_x;
	assign close_y = in_poly_q ? first_y_q : vertex_y;

	// a non-last word never needs the result register, so it may always retire
	assign move2    = v_s2 && (!last_s2 || !out_valid_q || !out_stall);
	assign load2    = !v_s2 || move2;
	assign in_stall = v_s1 && !load2;
	assign accept   = in_valid && !in_stall;

	pip_edge_diff u_prev_diff (
		.xi   (vertex_x),
		.yi   (vertex_y),
		.xj   (prev_x_q),
		.yj   (prev_y_q),
		.px   (point_x),
		.py   (point_y),
		.diff (prev_diff)
	);

	pip_edge_diff u_close_diff (
		.xi   (vertex_x),
		.yi   (vertex_y),
		.xj   (close_x),
		.yj   (close_y),
		.px   (point_x),
		.py   (point_y),
		.diff (close_diff)
	);

	// track the open polygon on every accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_poly_q <= 1'b0;
		end else if (accept) begin
			in_poly_q <= !last_vertex;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!in_poly_q) begin
				first_x_q <= vertex_x;
				first_y_q <= vertex_y;
			end
			prev_x_q <= vertex_x;
			prev_y_q <= vertex_y;
		end
	end

	// stage 1: differences
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prev_diff_s1  <= prev_diff;
			close_diff_s1 <= close_diff;
			last_s1       <= last_vertex;
			edge_ok_s1    <= in_poly_q;
		end
	end

	// stage 2: products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (load2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load2 && v_s1) begin
			last_s2    <= last_s1;
			edge_ok_s2 <= edge_ok_s1;
		end
	end

	pip_edge_mul u_prev_mul (
		.clk     (clk),
		.load    (load2 && v_s1),
		.diff_s1 (prev_diff_s1),
		.prod_s2 (prev_prod_s2)
	);

	pip_edge_mul u_close_mul (
		.clk     (clk),
		.load    (load2 && v_s1),
		.diff_s1 (close_diff_s1),
		.prod_s2 (close_prod_s2)
	);

	pip_edge_cmp u_prev_cmp (
		.prod    (prev_prod_s2),
		.crossed (prev_cross)
	);

	pip_edge_cmp u_close_cmp (
		.prod    (close_prod_s2),
		.crossed (close_cross)
	);

	// drop the previous-edge test on the opening vertex, the closing test
	// on all but the last
	assign flip = (edge_ok_s2 && prev_cross) ^ (last_s2 && close_cross);

	// stage 3: parity and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (move2) begin
				parity_q <= last_s2 ? 1'b0 : (parity_q ^ flip);
			end
			if (move2 && last_s2) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move2 && last_s2) begin
			inside_res <= parity_q ^ flip;
		end
	end

	assign out_valid = out_valid_q;

	// input stalls only behind a held stage-one word
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1)
		else $error("in_stall raised with stage one empty");

	// a retired last word leaves the parity clear
	a_parity_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(move2 && last_s2) |=> !parity_q)
		else $error("parity not cleared after a polygon result");

	// a result appears only after a last word retired
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(move2 && last_s2))
		else $error("result valid without a closing vertex");

	// a last vertex closes the polygon
	a_polygon_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_vertex) |=> !in_poly_q)
		else $error("polygon still open after its last vertex");

	// a waiting result is never overwritten
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !(move2 && last_s2))
		else $error("new result while previous one waits");

endmodule

`default_nettype wire

// ===== bench/point_in_polygon_test_tb.sv =====
// Self-checking bench for point_in_polygon_test: polygons stream in one vertex
// word at a time and each inside_res word is checked against a local predictor.
// Depends on pip_pkg and the point_in_polygon_test RTL.
`default_nettype none

module point_in_polygon_test_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = pip_pkg::COORD_BITS;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 8;

	typedef logic signed [CW-1:0] coord_t;
	typedef enum int {SPREAD_NEAR, SPREAD_WIDE, SPREAD_CORNER} spread_t;

	localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_stall;
	coord_t vertex_x = '0;
	coord_t vertex_y = '0;
	coord_t point_x = '0;
	coord_t point_y = '0;
	logic   last_vertex = 1'b0;
	logic   out_valid;
	logic   out_stall = 1'b0;
	logic   inside_res;

	// expected inside_res words, oldest first
	bit inside_q[$];

	// predictor copy of the polygon state
	coord_t poly_first_x, poly_first_y, poly_prev_x, poly_prev_y;
	bit     poly_parity = 1'b0;
	bit     poly_open = 1'b0;

	// idling controls shared between the tests and the two sides
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;
	int rx_hold_request = 0;

	int errors = 0;
	int vertices_sent = 0;
	int polygons_sent = 0;
	int results_seen = 0;
	int cycle_count = 0;
	int in_stall_cycles = 0;

	point_in_polygon_test dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.vertex_x    (vertex_x),
		.vertex_y    (vertex_y),
		.point_x     (point_x),
		.point_y     (point_y),
		.last_vertex (last_vertex),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.inside_res  (inside_res)
	);

	always #5 clk = ~clk;

	// Exact crossing test of the edge (xi,yi)-(xj,yj) against the horizontal
	// ray left of (px,py). Differences take one extra bit and products twice
	// that, so the cross-multiplied comparison never wraps.
	function automatic bit edge_crossed(input coord_t xi, yi, xj, yj, px, py);
		logic signed [CW:0]     dy, dyi, dxj, dxp;
		logic signed [2*CW+1:0] lhs, rhs;
		if ((yi < py) == (yj < py))
			return 1'b0;
		dy  = {yj[CW-1], yj} - {yi[CW-1], yi};
		dyi = {py[CW-1], py} - {yi[CW-1], yi};
		dxj = {xj[CW-1], xj} - {xi[CW-1], xi};
		dxp = {px[CW-1], px} - {xi[CW-1], xi};
		lhs = dyi * dxj;
		rhs = dxp * dy;
		// the sign of dy flips the sense of the comparison
		return (dy > 0) ? (lhs < rhs) : (rhs < lhs);
	endfunction

	// Advance the predicted polygon state by one vertex; returns 1 when the
	// vertex closes a polygon, with the even-odd verdict in verdict.
	function automatic bit track_vertex(input coord_t vx, vy, px, py, input bit last,
			output bit verdict);
		verdict = 1'b0;
		if (!poly_open) begin
			// opening vertex: latch it, no edge yet
			poly_first_x = vx;
			poly_first_y = vy;
			poly_open = 1'b1;
		end else if (edge_crossed(vx, vy, poly_prev_x, poly_prev_y, px, py)) begin
			poly_parity = ~poly_parity;
		end
		poly_prev_x = vx;
		poly_prev_y = vy;
		if (!last)
			return 1'b0;
		// closing edge back to the first vertex
		if (edge_crossed(vx, vy, poly_first_x, poly_first_y, px, py))
			poly_parity = ~poly_parity;
		verdict = poly_parity;
		poly_parity = 1'b0;
		poly_open = 1'b0;
		return 1'b1;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Offer one vertex word, hold it until accepted, predict, then idle a while.
	// Called at a rising edge, returns at a rising edge.
	task automatic send_vertex(input coord_t vx, vy, px, py, input bit last);
		bit          closes, verdict;
		int unsigned gap;
		vertex_x    <= vx;
		vertex_y    <= vy;
		point_x     <= px;
		point_y     <= py;
		last_vertex <= last;
		in_valid    <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		closes = track_vertex(vx, vy, px, py, last, verdict);
		vertices_sent++;
		if (closes) begin
			inside_q.push_back(verdict);
			polygons_sent++;
		end
		gap = tx_quiet ? 0 : idle_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold the sender until every expected word has come, then let the pipe settle.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (inside_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic coord_t pick_coord(input spread_t spread, input coord_t centre,
			input int unsigned reach);
		case (spread)
			SPREAD_NEAR:
				return centre + coord_t'($urandom_range(0, 2 * reach)) - coord_t'(reach);
			SPREAD_WIDE:
				return coord_t'($urandom);
			default: begin
				case ($urandom_range(0, 5))
					0: return C_MAX;
					1: return C_MIN;
					2: return '0;
					3: return '1;
					4: return coord_t'(1);
					default: return coord_t'($urandom);
				endcase
			end
		endcase
	endfunction

	// Degenerate polygons, a square with the point inside and on an edge, a triangle
	// with the point on a corner, and a point that moves between vertices.
	task automatic test_directed_shapes();
		// one vertex: its own edge never crosses
		send_vertex(5, 5, 10, 5, 1'b1);
		// two vertices: the same edge twice
		send_vertex(-20, -20, 0, 0, 1'b0);
		send_vertex(20, 20, 0, 0, 1'b1);
		// square with horizontal edges, point at centre
		send_vertex(-10, -10, 0, 0, 1'b0);
		send_vertex(10, -10, 0, 0, 1'b0);
		send_vertex(10, 10, 0, 0, 1'b0);
		send_vertex(-10, 10, 0, 0, 1'b1);
		// point on the right edge
		send_vertex(-10, -10, 10, 0, 1'b0);
		send_vertex(10, -10, 10, 0, 1'b0);
		send_vertex(10, 10, 10, 0, 1'b0);
		send_vertex(-10, 10, 10, 0, 1'b1);
		// point on a corner level with a horizontal edge
		send_vertex(-10, -10, -10, -10, 1'b0);
		send_vertex(10, -10, -10, -10, 1'b0);
		send_vertex(0, 10, -10, -10, 1'b1);
		// point moves while the polygon is open
		send_vertex(-10, -10, 0, 0, 1'b0);
		send_vertex(10, -10, 50, 0, 1'b0);
		send_vertex(10, 10, 5, 5, 1'b0);
		send_vertex(-10, 10, -50, 3, 1'b1);
		wait_for_results();
	endtask

	// Full-range coordinates, so the differences and products use every bit.
	task automatic test_extreme_coords();
		send_vertex(C_MIN, C_MIN, 0, 0, 1'b0);
		send_vertex(C_MAX, C_MIN, 0, 0, 1'b0);
		send_vertex(0, C_MAX, 0, 0, 1'b1);
		send_vertex(C_MIN, C_MIN, C_MAX, C_MAX, 1'b0);
		send_vertex(C_MAX, C_MAX, C_MAX, C_MAX, 1'b0);
		send_vertex(C_MIN, C_MAX, C_MAX, C_MAX, 1'b1);
		send_vertex(C_MAX, C_MIN, C_MIN, 0, 1'b0);
		send_vertex(C_MAX, C_MAX, C_MIN, 0, 1'b0);
		send_vertex(C_MIN, C_MAX, C_MIN, 0, 1'b1);
		wait_for_results();
	endtask

	// Random polygons, mostly of ordinary size, with vertices spread close to
	// the point (frequent ties and crossings), across the whole range, or on
	// the extremes.
	task automatic test_random_polygons(input int n_vertices);
		int          stop_at, n_sides, r;
		spread_t     spread;
		int unsigned reach;
		bit          moving;
		coord_t      px, py;
		stop_at = vertices_sent + n_vertices;
		while (vertices_sent < stop_at) begin
			r = $urandom_range(0, 99);
			n_sides = (r < 10) ? $urandom_range(1, 2) :
			          (r < 90) ? $urandom_range(3, 8) : $urandom_range(9, 20);
			r = $urandom_range(0, 99);
			spread = (r < 60) ? SPREAD_NEAR : (r < 85) ? SPREAD_WIDE : SPREAD_CORNER;
			reach = $urandom_range(0, 1) ? 8 : 1000;
			moving = ($urandom_range(0, 9) == 0);
			// a run with no idling on either side now and then
			tx_quiet = ($urandom_range(0, 4) == 0);
			rx_quiet = tx_quiet;
			px = $urandom_range(0, 1) ? coord_t'($urandom) : coord_t'($urandom_range(0, 200)) - 100;
			py = $urandom_range(0, 1) ? coord_t'($urandom) : coord_t'($urandom_range(0, 200)) - 100;
			for (int k = 0; k < n_sides; k++) begin
				if (moving && k != 0) begin
					px = pick_coord(SPREAD_NEAR, px, reach);
					py = pick_coord(SPREAD_NEAR, py, reach);
				end
				send_vertex(pick_coord(spread, px, reach), pick_coord(spread, py, reach),
						px, py, k == n_sides - 1);
			end
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	// Hold the result side off for a long stretch while triangles keep coming,
	// so the pipe fills and the block stalls its input; then drain.
	task automatic test_output_hold_off();
		coord_t px, py;
		tx_quiet = 1'b1;
		rx_hold_request = 300;
		for (int k = 0; k < 12; k++) begin
			px = coord_t'($urandom_range(0, 40)) - 20;
			py = coord_t'($urandom_range(0, 40)) - 20;
			send_vertex(pick_coord(SPREAD_NEAR, px, 30), pick_coord(SPREAD_NEAR, py, 30),
					px, py, 1'b0);
			send_vertex(pick_coord(SPREAD_NEAR, px, 30), pick_coord(SPREAD_NEAR, py, 30),
					px, py, 1'b0);
			send_vertex(pick_coord(SPREAD_NEAR, px, 30), pick_coord(SPREAD_NEAR, py, 30),
					px, py, 1'b1);
		end
		tx_quiet = 1'b0;
		wait_for_results();
	endtask

	// Result side: check each accepted word, then choose the next stall value.
	always @(posedge clk) begin
		bit          want;
		int unsigned r;
		static int   hold_left = 0;
		static int   run_left = 0;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (inside_q.size() == 0) begin
				$display("%0t ns: inside_res word with none expected, actual %b",
						$time, inside_res);
				errors++;
			end else begin
				want = inside_q.pop_front();
				results_seen++;
				if (inside_res !== want) begin
					$display("%0t ns: inside_res mismatch, expected %b, actual %b",
							$time, want, inside_res);
					errors++;
				end
			end
		end
		if (rx_hold_request != 0) begin
			hold_left = rx_hold_request;
			rx_hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (run_left > 0) begin
			run_left--;
			out_stall <= 1'b1;
		end else if (rx_quiet) begin
			out_stall <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				out_stall <= 1'b0;
			end else if (r < 93) begin
				run_left = $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				run_left = $urandom_range(5, 40);
				out_stall <= 1'b1;
			end
		end
	end

	// Watchdog: drop the run if it never finishes.
	always @(posedge clk) begin
		cycle_count++;
		if (in_valid && in_stall === 1'b1)
			in_stall_cycles++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected",
					cycle_count, inside_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_shapes();
		test_extreme_coords();
		test_random_polygons(270);
		test_output_hold_off();
		test_random_polygons(320);
		wait_for_results();
		$display("Checked %0d verdicts from %0d polygons (%0d vertices) in %0d cycles.",
				results_seen, polygons_sent, vertices_sent, cycle_count);
		$display("Input held off for %0d cycles; %0d errors.", in_stall_cycles, errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/pip_pkg.sv
src/pip_edge_diff.sv
src/pip_edge_mul.sv
src/pip_edge_cmp.sv
src/point_in_polygon_test.sv
bench/point_in_polygon_test_tb.sv
